/* hw/rtl/intdiv_pkg.sv */
// ----------------------------------------------------------------------------
// Integer divider package
// Shared constants and the sign/zero flag bundle carried down the pipeline.
// ----------------------------------------------------------------------------
package intdiv_pkg;

  localparam int unsigned DataWidthDef = 32;

  typedef struct packed {
    logic neg_quo;
    logic neg_rem;
    logic div_zero;
  } intdiv_flags_t;

endpackage

/* hw/rtl/intdiv_step.sv */
// ----------------------------------------------------------------------------
// Integer divider quotient step
// One registered restoring shift-subtract step for a fixed quotient bit.
// ----------------------------------------------------------------------------
module intdiv_step #(
  parameter int unsigned DATA_WIDTH = intdiv_pkg::DataWidthDef,
  parameter int unsigned BIT_POS    = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [DATA_WIDTH-1:0]    rem_i,
  input  logic [DATA_WIDTH-1:0]    quo_i,
  input  logic [DATA_WIDTH-1:0]    den_i,
  input  intdiv_pkg::intdiv_flags_t flags_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic [DATA_WIDTH-1:0]    rem_o,
  output logic [DATA_WIDTH-1:0]    quo_o,
  output logic [DATA_WIDTH-1:0]    den_o,
  output intdiv_pkg::intdiv_flags_t flags_o
);

  localparam logic [DATA_WIDTH-1:0] LowMask =
    (DATA_WIDTH'(1) << BIT_POS) - DATA_WIDTH'(1);

  logic                      valid_q;
  logic [DATA_WIDTH-1:0]     rem_q, rem_d;
  logic [DATA_WIDTH-1:0]     quo_q, quo_d;
  logic [DATA_WIDTH-1:0]     den_q;
  intdiv_pkg::intdiv_flags_t flags_q;
  logic [DATA_WIDTH-1:0]     rem_hi;
  logic [DATA_WIDTH:0]       diff;
  logic                      load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    rem_hi = rem_i >> BIT_POS;
    diff   = {1'b0, rem_hi} - {1'b0, den_i};
    rem_d  = rem_i;
    quo_d  = quo_i;
    if (!diff[DATA_WIDTH]) begin
      rem_d          = (diff[DATA_WIDTH-1:0] << BIT_POS) | (rem_i & LowMask);
      quo_d[BIT_POS] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q   <= rem_d;
      quo_q   <= quo_d;
      den_q   <= den_i;
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign den_o   = den_q;
  assign flags_o = flags_q;

endmodule

/* hw/rtl/integer_divider_signed_unsigned_core.sv */
// ----------------------------------------------------------------------------
// Signed/unsigned integer divider core
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_ready_o | action_i, dividend_in_i, divisor_in_i
//   out     | output    | out_valid_o/out_ready_i | quotient_out_o, remainder_out_o,
//           |           |                       | divide_by_zero_o
//
// One transaction enters per cycle while in_ready_o is high; each one passes the
// operand register, one stage per quotient bit and the sign fixup/output register.
// Each stage holds its own valid bit; a stage moves when it is empty or the
// next one takes its transaction, so bubbles close up under a stall.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module integer_divider_signed_unsigned_core #(
  parameter int unsigned DATA_WIDTH = intdiv_pkg::DataWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  action_i,
  input  logic [DATA_WIDTH-1:0] dividend_in_i,
  input  logic [DATA_WIDTH-1:0] divisor_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_WIDTH-1:0] quotient_out_o,
  output logic [DATA_WIDTH-1:0] remainder_out_o,
  output logic                  divide_by_zero_o
);

  // operand register
  logic                      op_valid_q;
  logic [DATA_WIDTH-1:0]     op_num_q, op_num_d;
  logic [DATA_WIDTH-1:0]     op_den_q, op_den_d;
  intdiv_pkg::intdiv_flags_t op_flags_q, op_flags_d;
  logic                      op_ready;
  logic                      a_neg, b_neg;

  assign a_neg = action_i && dividend_in_i[DATA_WIDTH-1];
  assign b_neg = action_i && divisor_in_i[DATA_WIDTH-1];

  always_comb begin
    op_num_d            = a_neg ? (DATA_WIDTH'(0) - dividend_in_i) : dividend_in_i;
    op_den_d            = b_neg ? (DATA_WIDTH'(0) - divisor_in_i) : divisor_in_i;
    op_flags_d.neg_quo  = a_neg ^ b_neg;
    op_flags_d.neg_rem  = a_neg;
    op_flags_d.div_zero = (divisor_in_i == '0);
  end

  assign in_ready_o = !op_valid_q || op_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      op_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_num_q   <= op_num_d;
      op_den_q   <= op_den_d;
      op_flags_q <= op_flags_d;
    end
  end

  // quotient stages
  logic                      st_valid [DATA_WIDTH+1];
  logic                      st_ready [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0]     st_rem   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0]     st_quo   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0]     st_den   [DATA_WIDTH+1];
  intdiv_pkg::intdiv_flags_t st_flags [DATA_WIDTH+1];

  assign st_valid[0] = op_valid_q;
  assign st_rem[0]   = op_num_q;
  assign st_quo[0]   = '0;
  assign st_den[0]   = op_den_q;
  assign st_flags[0] = op_flags_q;
  assign op_ready    = st_ready[0];

  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
    intdiv_step #(
      .DATA_WIDTH (DATA_WIDTH),
      .BIT_POS    (DATA_WIDTH - 1 - k)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_valid[k]),
      .ready_o (st_ready[k]),
      .rem_i   (st_rem[k]),
      .quo_i   (st_quo[k]),
      .den_i   (st_den[k]),
      .flags_i (st_flags[k]),
      .valid_o (st_valid[k+1]),
      .ready_i (st_ready[k+1]),
      .rem_o   (st_rem[k+1]),
      .quo_o   (st_quo[k+1]),
      .den_o   (st_den[k+1]),
      .flags_o (st_flags[k+1])
    );
  end

  // sign fixup and output register
  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] out_quo_q, out_quo_d;
  logic [DATA_WIDTH-1:0] out_rem_q, out_rem_d;
  logic                  out_dbz_q;
  intdiv_pkg::intdiv_flags_t fin_flags;

  assign fin_flags            = st_flags[DATA_WIDTH];
  assign st_ready[DATA_WIDTH] = !out_valid_q || out_ready_i;

  always_comb begin
    out_quo_d = fin_flags.neg_quo ? (DATA_WIDTH'(0) - st_quo[DATA_WIDTH])
                                  : st_quo[DATA_WIDTH];
    out_rem_d = fin_flags.neg_rem ? (DATA_WIDTH'(0) - st_rem[DATA_WIDTH])
                                  : st_rem[DATA_WIDTH];
    if (fin_flags.div_zero) begin
      out_quo_d = '0;
      out_rem_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (st_ready[DATA_WIDTH]) begin
      out_valid_q <= st_valid[DATA_WIDTH];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_valid[DATA_WIDTH] && st_ready[DATA_WIDTH]) begin
      out_quo_q <= out_quo_d;
      out_rem_q <= out_rem_d;
      out_dbz_q <= fin_flags.div_zero;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign quotient_out_o   = out_quo_q;
  assign remainder_out_o  = out_rem_q;
  assign divide_by_zero_o = out_dbz_q;

  // checks
  a_dbz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o |-> quotient_out_o == '0 && remainder_out_o == '0)
    else $error("divide by zero result not cleared");

  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  a_op_dbz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_valid_q && op_flags_q.div_zero |-> op_den_q == '0)
    else $error("zero divisor flag disagrees with operand");

endmodule

/* verif/intdiv_result_checker.sv */
// ----------------------------------------------------------------------------
// Integer divider result checker
// Watches both channels of the divider. Each accepted transaction on the
// input channel is divided by a restoring shift-subtract predictor, and the
// expected quotient, remainder and divide-by-zero flag are queued in order.
// Each accepted transaction on the output channel is compared field by field
// with the oldest queued result. Reports the failure count and the number of
// results still due.
// ----------------------------------------------------------------------------
module intdiv_result_checker #(
  parameter int unsigned DW = intdiv_pkg::DataWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  logic          action_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  logic [DW-1:0] quotient_i,
  input  logic [DW-1:0] remainder_i,
  input  logic          divide_by_zero_i,
  output int unsigned   fail_count_o,
  output int unsigned   pending_o
);

  typedef struct packed {
    logic [DW-1:0] quotient;
    logic [DW-1:0] remainder;
    logic          div_zero;
  } div_result_t;

  div_result_t due_results[$];

  function automatic div_result_t divide_words(input logic signed_mode,
                                               input logic [DW-1:0] num,
                                               input logic [DW-1:0] den);
    div_result_t   res;
    logic          num_neg;
    logic          den_neg;
    logic [DW-1:0] mag_num;
    logic [DW-1:0] mag_den;
    logic [DW-1:0] quo;
    logic [DW-1:0] rem;
    int            pos;
    res = '0;
    if (den == '0) begin
      res.div_zero = 1'b1;
      return res;
    end
    num_neg = signed_mode & num[DW-1];
    den_neg = signed_mode & den[DW-1];
    mag_num = num_neg ? -num : num;
    mag_den = den_neg ? -den : den;
    quo = '0;
    rem = mag_num;
    for (pos = DW - 1; pos >= 0; pos--) begin
      if ((rem >> pos) >= mag_den) begin
        rem = rem - (mag_den << pos);
        quo[pos] = 1'b1;
      end
    end
    res.quotient  = (num_neg ^ den_neg) ? -quo : quo;
    res.remainder = num_neg ? -rem : rem;
    return res;
  endfunction

  always @(posedge clk_i) begin
    div_result_t want;
    if (!rst_ni) begin
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          $error("result with no division outstanding: quotient %h remainder %h flag %b",
                 quotient_i, remainder_i, divide_by_zero_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = due_results.pop_front();
          if (quotient_i !== want.quotient) begin
            $error("quotient_out: expected %h, got %h", want.quotient, quotient_i);
            fail_count_o = fail_count_o + 1;
          end
          if (remainder_i !== want.remainder) begin
            $error("remainder_out: expected %h, got %h", want.remainder, remainder_i);
            fail_count_o = fail_count_o + 1;
          end
          if (divide_by_zero_i !== want.div_zero) begin
            $error("divide_by_zero: expected %b, got %b", want.div_zero, divide_by_zero_i);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        due_results.push_back(divide_words(action_i, dividend_i, divisor_i));
      end
      pending_o = due_results.size();
    end
  end

endmodule

/* verif/integer_divider_signed_unsigned_core_tb.sv */
// ----------------------------------------------------------------------------
// Integer divider core testbench
// Drives directed corner divisions, a back-pressure burst against a stalled
// receiver, and a long run of random signed and unsigned divisions with
// random gaps on both channels. Checking is done by the result checker
// instantiated beside the core.
// ----------------------------------------------------------------------------
module integer_divider_signed_unsigned_core_tb;

  localparam int unsigned DW = intdiv_pkg::DataWidthDef;
  localparam logic OpUnsigned = 1'b0;
  localparam logic OpSigned   = 1'b1;
  localparam int unsigned RandomOps = 800;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  logic          action_i;
  logic [DW-1:0] dividend_in_i;
  logic [DW-1:0] divisor_in_i;
  logic          out_valid_o;
  logic          out_ready_i;
  logic [DW-1:0] quotient_out_o;
  logic [DW-1:0] remainder_out_o;
  logic          divide_by_zero_o;

  int unsigned fail_count;
  int unsigned pending;

  bit          tx_idle_on;
  bit          rx_idle_on;
  bit          rx_hold_req;
  int unsigned rx_hold_left;

  integer_divider_signed_unsigned_core #(
    .DATA_WIDTH(DW)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .dividend_in_i   (dividend_in_i),
    .divisor_in_i    (divisor_in_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .quotient_out_o  (quotient_out_o),
    .remainder_out_o (remainder_out_o),
    .divide_by_zero_o(divide_by_zero_o)
  );

  intdiv_result_checker #(
    .DW(DW)
  ) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .action_i        (action_i),
    .dividend_i      (dividend_in_i),
    .divisor_i       (divisor_in_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .quotient_i      (quotient_out_o),
    .remainder_i     (remainder_out_o),
    .divide_by_zero_i(divide_by_zero_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int unsigned gap_cycles();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [DW-1:0] random_operand();
    logic [DW-1:0] val;
    case ($urandom_range(0, 9))
      4: val = $urandom_range(0, 15);
      5: val = -$urandom_range(1, 15);
      6: begin
        case ($urandom_range(0, 5))
          0: val = '0;
          1: val = 1;
          2: val = {1'b0, {(DW-1){1'b1}}};
          3: val = {1'b1, {(DW-1){1'b0}}};
          4: val = '1;
          default: val = {1'b1, {(DW-2){1'b0}}, 1'b1};
        endcase
      end
      7: val = $urandom >> $urandom_range(0, DW - 1);
      default: val = $urandom;
    endcase
    return val;
  endfunction

  // receiver: random stalls, plus one long hold on request
  initial begin
    out_ready_i  = 1'b0;
    rx_hold_left = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        out_ready_i <= 1'b0;
        rx_hold_left = rx_hold_left - 1;
      end else if (rx_hold_req) begin
        rx_hold_req  = 1'b0;
        rx_hold_left = 150;
        out_ready_i <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        rx_hold_left = gap_cycles() - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_division(input logic op, input logic [DW-1:0] num,
                               input logic [DW-1:0] den);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat (gap_cycles()) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= op;
    dividend_in_i <= num;
    divisor_in_i  <= den;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
  endtask

  initial begin
    logic op;
    logic [DW-1:0] den;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    action_i      = OpUnsigned;
    dividend_in_i = '0;
    divisor_in_i  = '0;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    rx_hold_req   = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_division(OpUnsigned, 32'h0000_0000, 32'h0000_0000);
    send_division(OpSigned,   32'h8000_0000, 32'h0000_0000);
    send_division(OpUnsigned, 32'hFFFF_FFFF, 32'h0000_0000);
    send_division(OpUnsigned, 32'h0000_0000, 32'h0000_0001);
    send_division(OpUnsigned, 32'hFFFF_FFFF, 32'h0000_0001);
    send_division(OpUnsigned, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_division(OpUnsigned, 32'h0000_0001, 32'hFFFF_FFFF);
    send_division(OpUnsigned, 32'h8000_0000, 32'h0000_0003);
    send_division(OpUnsigned, 32'hFFFF_FFFE, 32'h8000_0000);
    send_division(OpSigned,   32'h8000_0000, 32'hFFFF_FFFF);
    send_division(OpSigned,   32'h8000_0000, 32'h0000_0001);
    send_division(OpSigned,   32'h8000_0000, 32'h8000_0000);
    send_division(OpSigned,   32'h7FFF_FFFF, 32'h8000_0000);
    send_division(OpSigned,   32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_division(OpSigned,   32'h0000_0007, 32'hFFFF_FFFE);
    send_division(OpSigned,   32'hFFFF_FFF9, 32'h0000_0002);
    send_division(OpSigned,   32'hFFFF_FFF9, 32'hFFFF_FFFE);
    send_division(OpSigned,   32'h0000_0007, 32'h0000_0002);
    send_division(OpSigned,   32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_division(OpSigned,   32'h0000_0000, 32'hFFFF_FFFF);
    send_division(OpUnsigned, 32'h1234_5678, 32'h0000_0010);
    send_division(OpSigned,   32'hEDCB_A988, 32'h0000_0010);

    // fill the pipeline against a held receiver, then let it empty
    tx_idle_on  = 1'b0;
    rx_hold_req = 1'b1;
    repeat (80) send_division(1'($urandom), random_operand(), random_operand() | 1);
    drain();

    for (int unsigned seg = 0; seg < RandomOps / 100; seg++) begin
      tx_idle_on = (seg % 3) != 1;
      rx_idle_on = (seg % 4) != 2;
      repeat (100) begin
        op  = 1'($urandom);
        den = ($urandom_range(0, 23) == 0) ? '0 : random_operand();
        send_division(op, random_operand(), den);
      end
    end

    drain();
    repeat (DW + 4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
